// File: sv/value_to_radix_digits_assert.svh
// Assertion macros for the radix digit converter.
// Uses clk and rst_n of the including module; no other dependencies.
`ifndef VALUE_TO_RADIX_DIGITS_ASSERT_SVH
`define VALUE_TO_RADIX_DIGITS_ASSERT_SVH

// Check a consequence in the same cycle as its condition
`define RTD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("radix digit converter: same-cycle check failed");

// Check a consequence in the cycle after its condition
`define RTD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("radix digit converter: next-cycle check failed");

`endif

// File: sv/rtd_pkg.sv
// Shared constants, reciprocal table and digit encoding for the radix digit converter.
// No dependencies.
package rtd_pkg;

    localparam int VALUE_BITS = 31;
    localparam int RADIX_W    = 5;
    localparam int CHAR_W     = 7;
    localparam int DIGIT_W    = 4;

    // Digit counter holds 0..VALUE_BITS, store index 0..VALUE_BITS-1
    localparam int CNT_W = $clog2(VALUE_BITS + 1);
    localparam int IDX_W = $clog2(VALUE_BITS);

    // Reciprocal scaled by 2^(VALUE_BITS+1): the estimate is exact or one low
    localparam int RECIP_SHIFT = VALUE_BITS + 1;
    localparam int RECIP_W     = VALUE_BITS + 1;
    localparam int PROD_W      = VALUE_BITS + RECIP_W;

    localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;
    localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;

    localparam int RADIX_ENTRIES = 17;
    localparam logic [127:0] RECIP_ONE = 128'd1 << RECIP_SHIFT;

    // floor(2^RECIP_SHIFT / radix); entries below two are never selected
    localparam logic [RECIP_W-1:0] RECIP_TABLE [RADIX_ENTRIES] = '{
        RECIP_W'(0),
        RECIP_W'(0),
        RECIP_W'(RECIP_ONE / 2),
        RECIP_W'(RECIP_ONE / 3),
        RECIP_W'(RECIP_ONE / 4),
        RECIP_W'(RECIP_ONE / 5),
        RECIP_W'(RECIP_ONE / 6),
        RECIP_W'(RECIP_ONE / 7),
        RECIP_W'(RECIP_ONE / 8),
        RECIP_W'(RECIP_ONE / 9),
        RECIP_W'(RECIP_ONE / 10),
        RECIP_W'(RECIP_ONE / 11),
        RECIP_W'(RECIP_ONE / 12),
        RECIP_W'(RECIP_ONE / 13),
        RECIP_W'(RECIP_ONE / 14),
        RECIP_W'(RECIP_ONE / 15),
        RECIP_W'(RECIP_ONE / 16)
    };

    localparam logic [CHAR_W-1:0]  CHAR_ZERO     = 7'd48;
    localparam logic [CHAR_W-1:0]  CHAR_LETTER_A = 7'd65;
    localparam logic [DIGIT_W-1:0] DIGIT_TEN     = 4'd10;

    // Encode a digit value as ASCII: '0'..'9', then 'A'..'F'
    function automatic logic [CHAR_W-1:0] digit_to_char(input logic [DIGIT_W-1:0] d);
        if (d < DIGIT_TEN)
            return CHAR_ZERO + CHAR_W'(d);
        else
            return CHAR_LETTER_A + CHAR_W'(d - DIGIT_TEN);
    endfunction

endpackage

// File: sv/rtd_in_if.sv
// Input channel of the radix digit converter: valid/ready with the value to convert.
// Depends on rtd_pkg.
interface rtd_in_if;
    import rtd_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [VALUE_BITS-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

// File: sv/rtd_out_if.sv
// Output channel of the radix digit converter: valid/ready with one ASCII digit.
// Depends on rtd_pkg.
interface rtd_out_if;
    import rtd_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] digit_char;
    logic              last_digit;

    modport source (output valid, output digit_char, output last_digit, input ready);
    modport sink   (input valid, input digit_char, input last_digit, output ready);
endinterface

// File: sv/rtd_recip_div.sv
// Shared divide-by-radix unit: registered reciprocal multiply, then a one-step correction.
// Depends on rtd_pkg (reciprocal table and widths).
module rtd_recip_div
(
    input  logic                          clk,
    input  logic                          start,
    input  logic [rtd_pkg::VALUE_BITS-1:0] dividend,
    input  logic [rtd_pkg::RADIX_W-1:0]    radix,
    output logic [rtd_pkg::VALUE_BITS-1:0] quotient,
    output logic [rtd_pkg::DIGIT_W-1:0]    remainder
);
    import rtd_pkg::*;

    logic [VALUE_BITS-1:0] dividend_reg;
    logic [RADIX_W-1:0]    radix_reg;
    logic [PROD_W-1:0]     product_reg;

    logic [VALUE_BITS-1:0] q_est;
    logic [VALUE_BITS-1:0] back_prod;
    logic [VALUE_BITS-1:0] rem_raw;
    logic [RADIX_W-1:0]    rem_small;

    // Capture operands and the reciprocal product
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dividend_reg <= dividend;
            radix_reg    <= radix;
            product_reg  <= PROD_W'(dividend) * PROD_W'(RECIP_TABLE[radix]);
        end
    end

    // Estimate is the true quotient or one below; the remainder stays under twice the radix
    always_comb
    begin
        q_est     = product_reg[PROD_W-1:RECIP_SHIFT];
        back_prod = q_est * VALUE_BITS'(radix_reg);
        rem_raw   = dividend_reg - back_prod;
        rem_small = rem_raw[RADIX_W-1:0];
        if (rem_small >= radix_reg)
        begin
            quotient  = q_est + VALUE_BITS'(1);
            remainder = DIGIT_W'(rem_small - radix_reg);
        end
        else
        begin
            quotient  = q_est;
            remainder = DIGIT_W'(rem_small);
        end
    end

endmodule

// File: sv/value_to_radix_digits.sv
// Radix digit converter: takes a value and emits its digits in the configured radix,
// most significant first, as ASCII. After the intake of a value, each digit goes through
// the shared reciprocal divider (multiply, then correct and store the remainder); the
// digits are then emitted one by one, holding while the sink is not ready. Radix 2 on the
// full 31-bit range gives up to 31 digits. The input is not ready while a value is being
// divided or emitted; the last digit sits in the output register while the next value is
// taken. The radix is written through cfg_wr_en/cfg_wr_data, resets to ten, and is
// clamped to 2..16.
// Depends on rtd_pkg, rtd_in_if, rtd_out_if, rtd_recip_div and the assertion header.
`include "value_to_radix_digits_assert.svh"

module value_to_radix_digits
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  logic [rtd_pkg::RADIX_W-1:0] cfg_wr_data,
    rtd_in_if.sink                     item,
    rtd_out_if.source                  digit
);
    import rtd_pkg::*;

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_DIVIDE,
        ST_FIX,
        ST_EMIT
    } state_t;

    state_t                state_reg,    state_next;
    logic [RADIX_W-1:0]    radix_reg,    radix_next;
    logic [VALUE_BITS-1:0] quot_reg,     quot_next;
    logic [CNT_W-1:0]      count_reg,    count_next;
    logic [IDX_W-1:0]      emit_idx_reg, emit_idx_next;
    logic                  out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0]     out_char_reg, out_char_next;
    logic                  out_last_reg, out_last_next;

    logic [DIGIT_W-1:0]    digit_store [VALUE_BITS];

    logic [RADIX_W-1:0]    radix_eff;
    logic                  div_start;
    logic [VALUE_BITS-1:0] div_quot;
    logic [DIGIT_W-1:0]    div_rem;
    logic                  out_free;
    logic                  item_take;

    // Clamp the programmed radix to the supported range
    always_comb
    begin
        if (radix_reg < RADIX_MIN)
            radix_eff = RADIX_MIN;
        else if (radix_reg > RADIX_MAX)
            radix_eff = RADIX_MAX;
        else
            radix_eff = radix_reg;
    end

    assign div_start = (state_reg == ST_DIVIDE);

    rtd_recip_div u_div
    (
        .clk       (clk),
        .start     (div_start),
        .dividend  (quot_reg),
        .radix     (radix_eff),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    // Store each remainder, least significant digit first
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_FIX)
            digit_store[count_reg[IDX_W-1:0]] <= div_rem;
    end

    assign item_take = item.valid && (state_reg == ST_IDLE);
    assign out_free  = !out_valid_reg || digit.ready;

    // Sequence division steps, then walk the store back out
    always_comb
    begin
        state_next     = state_reg;
        radix_next     = radix_reg;
        quot_next      = quot_reg;
        count_next     = count_reg;
        emit_idx_next  = emit_idx_reg;
        out_valid_next = out_valid_reg;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;

        if (cfg_wr_en)
            radix_next = cfg_wr_data;

        // Drop the output once its transaction completes
        if (out_valid_reg && digit.ready)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (item_take)
                begin
                    quot_next  = item.value;
                    count_next = '0;
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                state_next = ST_FIX;
            end
            ST_FIX:
            begin
                quot_next  = div_quot;
                count_next = count_reg + CNT_W'(1);
                if (div_quot == '0 || count_reg == CNT_W'(VALUE_BITS - 1))
                begin
                    emit_idx_next = count_reg[IDX_W-1:0];
                    state_next    = ST_EMIT;
                end
                else
                begin
                    state_next = ST_DIVIDE;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = digit_to_char(digit_store[emit_idx_reg]);
                    out_last_next  = (emit_idx_reg == '0);
                    if (emit_idx_reg == '0)
                        state_next = ST_IDLE;
                    else
                        emit_idx_next = emit_idx_reg - IDX_W'(1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            radix_reg     <= RADIX_RESET;
            quot_reg      <= '0;
            count_reg     <= '0;
            emit_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
            out_char_reg  <= '0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            radix_reg     <= radix_next;
            quot_reg      <= quot_next;
            count_reg     <= count_next;
            emit_idx_reg  <= emit_idx_next;
            out_valid_reg <= out_valid_next;
            out_char_reg  <= out_char_next;
            out_last_reg  <= out_last_next;
        end
    end

    assign item.ready       = (state_reg == ST_IDLE);
    assign digit.valid      = out_valid_reg;
    assign digit.digit_char = out_char_reg;
    assign digit.last_digit = out_last_reg;

    `RTD_ASSERT_NOW(a_store_in_range, state_reg == ST_FIX, count_reg < CNT_W'(VALUE_BITS))
    `RTD_ASSERT_NOW(a_emit_below_count, state_reg == ST_EMIT, CNT_W'(emit_idx_reg) < count_reg)
    `RTD_ASSERT_NOW(a_rem_below_radix, state_reg == ST_FIX, RADIX_W'(div_rem) < radix_eff)
    `RTD_ASSERT_NEXT(a_take_starts_divide, item_take, state_reg == ST_DIVIDE && count_reg == '0)

endmodule

// File: dv/tb.sv
// Self-checking testbench for value_to_radix_digits: directed and random values
// across radix settings, with an in-bench digit predictor and an in-order scoreboard.
// Depends on rtd_pkg, rtd_in_if, rtd_out_if and the value_to_radix_digits RTL.
`timescale 1ns / 100ps

module tb;
    import rtd_pkg::*;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } digit_t;

    localparam int MAX_REPORTS   = 10;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS   = 50;
    localparam int MAX_GAP       = 5;
    localparam int DRAIN_CYCLES  = 100;

    // Digit predictor and in-order store of expected digits
    class digit_scoreboard;
        logic [RADIX_W-1:0] radix_code;
        digit_t             pending_digits[$];
        int                 errors;
        int                 values_seen;
        int                 digits_seen;

        function new();
            radix_code  = RADIX_RESET;
            errors      = 0;
            values_seen = 0;
            digits_seen = 0;
        endfunction

        function void set_radix(logic [RADIX_W-1:0] code);
            radix_code = code;
        endfunction

        function int pending();
            return pending_digits.size();
        endfunction

        // Divide repeatedly, then queue the digits most significant first
        function void note_value(logic [VALUE_BITS-1:0] v);
            logic [VALUE_BITS-1:0] quot;
            logic [DIGIT_W-1:0]    rems[VALUE_BITS];
            int                    count;
            int                    base;
            digit_t                d;
            base = radix_code;
            if (base < RADIX_MIN)
                base = RADIX_MIN;
            if (base > RADIX_MAX)
                base = RADIX_MAX;
            quot  = v;
            count = 0;
            do
            begin
                rems[count] = DIGIT_W'(quot % base);
                quot        = quot / base;
                count++;
            end
            while (quot != 0 && count < VALUE_BITS);
            for (int k = count - 1; k >= 0; k--)
            begin
                if (rems[k] < DIGIT_TEN)
                    d.ch = CHAR_ZERO + CHAR_W'(rems[k]);
                else
                    d.ch = CHAR_LETTER_A + CHAR_W'(rems[k] - DIGIT_TEN);
                d.last = (k == 0);
                pending_digits.push_back(d);
            end
            values_seen++;
        endfunction

        function void report(string what);
            errors++;
            if (errors <= MAX_REPORTS)
                $display("ERROR: %s", what);
        endfunction

        // Compare one accepted digit against the oldest expectation
        function void check_digit(logic [CHAR_W-1:0] ch, logic last);
            digit_t exp_d;
            digits_seen++;
            if (pending_digits.size() == 0)
            begin
                report($sformatf("unexpected digit char=%0d last=%0b", ch, last));
                return;
            end
            exp_d = pending_digits.pop_front();
            if (ch !== exp_d.ch)
                report($sformatf("digit_char expected %0d got %0d", exp_d.ch, ch));
            if (last !== exp_d.last)
                report($sformatf("last_digit expected %0b got %0b", exp_d.last, last));
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    logic [RADIX_W-1:0] cfg_wr_data;

    rtd_in_if  item_ch();
    rtd_out_if digit_ch();

    digit_scoreboard sb;
    bit source_calm;
    bit sink_calm;
    int radix_writes;

    value_to_radix_digits dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .item        (item_ch),
        .digit       (digit_ch)
    );

    // Free-running clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Drive one value, waiting a random gap first; valid stays high for gap zero
    task automatic send_value(logic [VALUE_BITS-1:0] v);
        int gap;
        gap = source_calm ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_ch.valid <= 1'b1;
        item_ch.value <= v;
        do
            @(posedge clk);
        while (!item_ch.ready);
        sb.note_value(v);
    endtask

    // Drop valid after the last transaction of a phase
    task automatic end_phase();
        item_ch.valid <= 1'b0;
    endtask

    // Write the radix register once the converter has drained
    task automatic write_radix(logic [RADIX_W-1:0] code);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_wr_data <= code;
        cfg_wr_en   <= 1'b1;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        sb.set_radix(code);
        radix_writes++;
    endtask

    // Random value with a random bit length, so small and large magnitudes mix
    function automatic logic [VALUE_BITS-1:0] random_value();
        int          len;
        logic [31:0] raw;
        len = $urandom_range(0, VALUE_BITS);
        raw = $urandom;
        if (len == 0)
            return '0;
        return VALUE_BITS'(raw & ((32'h1 << len) - 32'h1));
    endfunction

    // Accept digits with random stalls, flipping between calm and stalling stretches
    initial
    begin
        int stall;
        @(posedge rst_n);
        forever
        begin
            if ($urandom_range(0, 39) == 0)
                sink_calm = ~sink_calm;
            stall = sink_calm ? 0 : $urandom_range(0, MAX_GAP);
            if (stall > 0)
            begin
                digit_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            digit_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!digit_ch.valid);
            sb.check_digit(digit_ch.digit_char, digit_ch.last_digit);
        end
    end

    // Main sequence: reset, directed values, random phases, drain and verdict
    initial
    begin
        sb           = new();
        source_calm  = 1'b0;
        sink_calm    = 1'b0;
        radix_writes = 0;
        rst_n          <= 1'b0;
        cfg_wr_en      <= 1'b0;
        cfg_wr_data    <= '0;
        item_ch.valid  <= 1'b0;
        item_ch.value  <= '0;
        digit_ch.ready <= 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset radix of ten: zero, edges of the digit range, full scale
        send_value('0);
        send_value(VALUE_BITS'(9));
        send_value(VALUE_BITS'(10));
        send_value(VALUE_BITS'(1234567890));
        send_value({VALUE_BITS{1'b1}});
        end_phase();

        // Binary: longest digit strings
        write_radix(5'd2);
        send_value('0);
        send_value(VALUE_BITS'(1));
        send_value({VALUE_BITS{1'b1}});
        send_value(VALUE_BITS'(32'h2AAA_AAAA));
        end_phase();

        // Hex: every letter digit
        write_radix(5'd16);
        send_value(VALUE_BITS'(15));
        send_value(VALUE_BITS'(32'h7EDC_BA98));
        send_value(VALUE_BITS'(32'h0ABC_DEF0));
        end_phase();

        // Radix codes below two act as binary
        write_radix(5'd0);
        send_value(VALUE_BITS'(5));
        send_value('0);
        end_phase();
        write_radix(5'd1);
        send_value(VALUE_BITS'(6));
        end_phase();

        // Radix codes above sixteen act as hex
        write_radix(5'd17);
        send_value(VALUE_BITS'(255));
        end_phase();
        write_radix(5'd31);
        send_value({VALUE_BITS{1'b1}});
        send_value('0);
        end_phase();

        // Odd radices near the ends
        write_radix(5'd3);
        send_value({VALUE_BITS{1'b1}});
        end_phase();
        write_radix(5'd15);
        send_value(VALUE_BITS'(224));
        end_phase();

        // Random phases, each under its own radix and pacing
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            if ($urandom_range(0, 4) == 0)
                write_radix(RADIX_W'($urandom_range(0, 31)));
            else
                write_radix(RADIX_W'($urandom_range(2, 16)));
            source_calm = ($urandom_range(0, 2) == 0);
            for (int i = 0; i < PHASE_ITEMS; i++)
                send_value(random_value());
            end_phase();
        end

        // Drain outstanding digits, then allow trailing cycles for strays
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Converted %0d values into %0d digits across %0d radix writes.",
                 sb.values_seen, sb.digits_seen, radix_writes);
        $display("Mismatches: %0d, digits still outstanding: %0d.",
                 sb.errors, sb.pending());
        if (sb.errors == 0 && sb.pending() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2000000;
        $display("Timeout: converter stopped making progress.");
        $display("FAILURE");
        $finish;
    end

endmodule
